### rtl/show_container_stream_validator_top_assert.svh
// Assertion macros for the show container stream validator
`ifndef SHOW_CONTAINER_STREAM_VALIDATOR_TOP_ASSERT_SVH
`define SHOW_CONTAINER_STREAM_VALIDATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SCV_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SCV_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SCV_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define SCV_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

### rtl/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types and constants of the show container stream validator.
// ----------------------------------------------------------------------------
package scv_pkg;
  localparam int unsigned ID_LIMIT_DEF   = 128;
  localparam int unsigned NAME_LIMIT_DEF = 256;
  localparam logic [4:0]  TAG_IDLE = 5'd31;
  localparam logic [22:0] OFS_MAX  = 23'h7FFFFF;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_TRUNC = 4'd1, ERR_MAGIC = 4'd2, ERR_MAJOR = 4'd3,
    ERR_MINOR = 4'd4, ERR_SONGS = 4'd5, ERR_SCENES = 4'd6, ERR_CLIPS = 4'd7,
    ERR_STRLEN = 4'd8, ERR_CODE = 4'd9, ERR_TRAIL = 4'd10, ERR_SIZE = 4'd11
  } err_t;

  typedef enum logic [2:0] {
    REG_MAJOR = 3'd0, REG_MINOR = 3'd1, REG_SONGS = 3'd2, REG_SCENES = 3'd3,
    REG_CLIPS = 3'd4, REG_BEHAV = 3'd5, REG_FSIZE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] expected_major;
    logic [15:0] newest_minor;
    logic [7:0]  max_songs;
    logic [15:0] max_scenes;
    logic [15:0] max_clips;
    logic [7:0]  max_behaviour_code;
    logic [22:0] max_file_bytes;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  field_tag;
    logic [15:0] field_byte_index;
    logic [3:0]  error_code;
    logic [22:0] error_offset;
    logic        finished;
    logic        file_ok;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h41; 3'd1: r = 8'h45; 3'd2: r = 8'h59; 3'd3: r = 8'h4C;
      3'd4: r = 8'h41; 3'd5: r = 8'h53; 3'd6: r = 8'h48; default: r = 8'h57;
    endcase
    return r;
  endfunction

  // fixed byte count per tag; zero marks a text sized by its length, or the idle tag
  function automatic logic [3:0] field_len(input logic [4:0] t);
    logic [3:0] r;
    unique case (t)
      5'd0, 5'd8, 5'd11, 5'd28, 5'd29: r = 4'd8;
      5'd3, 5'd10, 5'd12, 5'd13, 5'd20, 5'd21: r = 4'd4;
      5'd22, 5'd23: r = 4'd1;
      5'd30: r = 4'd3;
      5'd5, 5'd7, 5'd15, 5'd17, 5'd19, 5'd25, 5'd27, 5'd31: r = 4'd0;
      default: r = 4'd2;
    endcase
    return r;
  endfunction
endpackage

### rtl/scv_fifo.sv
// ----------------------------------------------------------------------------
// scv_fifo
// Two-entry item queue between the front and the back of the validator.
// ----------------------------------------------------------------------------
module scv_fifo import scv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_data
);
  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

### rtl/scv_cfg.sv
// ----------------------------------------------------------------------------
// scv_cfg
// Configuration register file; decodes writes by register index.
// ----------------------------------------------------------------------------
module scv_cfg import scv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [22:0] wr_data,
  output cfg_t        cfg
);
  cfg_t cfg_r;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_major     <= 16'd1;
      cfg_r.newest_minor       <= 16'd0;
      cfg_r.max_songs          <= 8'd15;
      cfg_r.max_scenes         <= 16'd256;
      cfg_r.max_clips          <= 16'd4096;
      cfg_r.max_behaviour_code <= 8'd1;
      cfg_r.max_file_bytes     <= 23'd4194304;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_MAJOR:  cfg_r.expected_major     <= wr_data[15:0];
        REG_MINOR:  cfg_r.newest_minor       <= wr_data[15:0];
        REG_SONGS:  cfg_r.max_songs          <= wr_data[7:0];
        REG_SCENES: cfg_r.max_scenes         <= wr_data[15:0];
        REG_CLIPS:  cfg_r.max_clips          <= wr_data[15:0];
        REG_BEHAV:  cfg_r.max_behaviour_code <= wr_data[7:0];
        REG_FSIZE:  cfg_r.max_file_bytes     <= wr_data;
        default: ;
      endcase
    end
  end
endmodule

### rtl/scv_parse.sv
// ----------------------------------------------------------------------------
// scv_parse
// Back part: walks the show file layout one byte a cycle while the output is
// not stalled, and registers the per-byte result in an output stage.
// ----------------------------------------------------------------------------
module scv_parse import scv_pkg::*; #(
  parameter int unsigned ID_LIMIT   = ID_LIMIT_DEF,
  parameter int unsigned NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);
  localparam logic [31:0] ID_LIM   = 32'(ID_LIMIT);
  localparam logic [31:0] NAME_LIM = 32'(NAME_LIMIT);

  logic [4:0]  state_r, state_nxt;
  logic [15:0] bif_r, bif_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  songs_r, songs_nxt;
  logic [15:0] scenes_r, scenes_nxt;
  logic [15:0] clips_r, clips_nxt;
  logic [22:0] ofs_r, ofs_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [22:0] eofs_r, eofs_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic        ov_r;
  result_t     res_r, res_nxt;

  logic        step;
  logic [7:0]  b;
  logic [22:0] endo;
  logic [3:0]  flen;
  logic [15:0] bif_inc;
  logic [31:0] a;
  logic        done;

  assign in_ready  = !ov_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign b         = in_item.data_byte;

  always_comb begin
    logic [31:0] len;
    logic [4:0]  tag;
    logic [15:0] idx;
    logic [31:0] limit;
    logic [4:0]  txt, nxt;
    logic        strfld;
    state_nxt  = state_r;  bif_nxt = bif_r; acc_nxt = acc_r;
    songs_nxt  = songs_r;  scenes_nxt = scenes_r; clips_nxt = clips_r;
    err_nxt    = err_r;    eofs_nxt = eofs_r; pend_nxt = pend_r;
    endo       = (ofs_r == OFS_MAX) ? OFS_MAX : ofs_r + 23'd1;
    tag        = TAG_IDLE; idx = 16'd0;
    flen       = field_len(state_r);
    bif_inc    = bif_r + 16'd1;
    a          = acc_r;
    done       = 1'b0;
    len        = 32'd0; limit = 32'd0; txt = 5'd0; nxt = 5'd0; strfld = 1'b0;

    if (err_r == ERR_NONE && state_r != TAG_IDLE) begin
      tag = state_r;
      idx = bif_r;
      if (state_r == 5'd0) begin
        if (b != magic_byte(bif_r[2:0])) pend_nxt = ERR_MAGIC;
      end else if (flen != 4'd0 && bif_r < 16'd4) begin
        unique case (bif_r[1:0])
          2'd0: a = acc_r | {24'd0, b};
          2'd1: a = acc_r | {16'd0, b, 8'd0};
          2'd2: a = acc_r | {8'd0, b, 16'd0};
          default: a = acc_r | {b, 24'd0};
        endcase
      end
      acc_nxt = a;
      bif_nxt = bif_inc;
      len     = (flen != 4'd0) ? {28'd0, flen} : a;
      done    = ({16'd0, bif_inc} >= len);
      if (done) begin
        // string length fields share one exit
        unique case (state_r)
          5'd4:  begin strfld = 1'b1; limit = ID_LIM;   txt = 5'd5;  nxt = 5'd6;  end
          5'd6:  begin strfld = 1'b1; limit = NAME_LIM; txt = 5'd7;  nxt = 5'd8;  end
          5'd14: begin strfld = 1'b1; limit = ID_LIM;   txt = 5'd15; nxt = 5'd16; end
          5'd16: begin strfld = 1'b1; limit = NAME_LIM; txt = 5'd17; nxt = 5'd18; end
          5'd18: begin strfld = 1'b1; limit = ID_LIM;   txt = 5'd19; nxt = 5'd20; end
          5'd24: begin strfld = 1'b1; limit = ID_LIM;   txt = 5'd25; nxt = 5'd26; end
          5'd26: begin strfld = 1'b1; limit = ID_LIM;   txt = 5'd27; nxt = 5'd28; end
          default: ;
        endcase
        bif_nxt = 16'd0;
        acc_nxt = 32'd0;
        if (strfld) begin
          if (a > limit) begin
            err_nxt = ERR_STRLEN; eofs_nxt = endo; state_nxt = TAG_IDLE;
          end else if (a == 32'd0) begin
            state_nxt = nxt;
          end else begin
            state_nxt = txt; acc_nxt = a;
          end
        end else begin
          unique case (state_r)
            5'd0: begin
              if (pend_nxt != ERR_NONE) begin
                pend_nxt = ERR_NONE; err_nxt = ERR_MAGIC; eofs_nxt = 23'd0;
                state_nxt = TAG_IDLE;
              end else state_nxt = 5'd1;
            end
            5'd1: begin
              if (a != {16'd0, cfg.expected_major}) pend_nxt = ERR_MAJOR;
              state_nxt = 5'd2;
            end
            5'd2: begin
              if (pend_r == ERR_NONE && a > {16'd0, cfg.newest_minor}) pend_nxt = ERR_MINOR;
              state_nxt = 5'd3;
            end
            5'd3: begin
              if (pend_r != ERR_NONE) begin
                pend_nxt = ERR_NONE; err_nxt = pend_r; eofs_nxt = endo;
                state_nxt = TAG_IDLE;
              end else if (a == 32'd0 || a > {24'd0, cfg.max_songs}) begin
                err_nxt = ERR_SONGS; eofs_nxt = endo; state_nxt = TAG_IDLE;
              end else begin
                songs_nxt = a[7:0]; state_nxt = 5'd4;
              end
            end
            5'd12: begin
              scenes_nxt = (a == 32'd0 || a > {16'd0, cfg.max_scenes}) ? 16'd0 : a[15:0];
              state_nxt  = 5'd13;
            end
            5'd13: begin
              if (scenes_r == 16'd0) begin
                err_nxt = ERR_SCENES; eofs_nxt = endo; state_nxt = TAG_IDLE;
              end else if (a > {16'd0, cfg.max_clips}) begin
                err_nxt = ERR_CLIPS; eofs_nxt = endo; state_nxt = TAG_IDLE;
              end else begin
                clips_nxt = a[15:0]; state_nxt = 5'd14;
              end
            end
            5'd22: begin
              if (a > 32'd1) pend_nxt = ERR_CODE;
              state_nxt = 5'd23;
            end
            5'd23: begin
              if (pend_r != ERR_NONE || a > {24'd0, cfg.max_behaviour_code}) begin
                pend_nxt = ERR_NONE; err_nxt = ERR_CODE; eofs_nxt = endo;
                state_nxt = TAG_IDLE;
              end else begin
                if (scenes_r != 16'd0) scenes_nxt = scenes_r - 16'd1;
                if (scenes_nxt != 16'd0) state_nxt = 5'd14;
                else if (clips_r != 16'd0) state_nxt = 5'd24;
                else begin
                  if (songs_r != 8'd0) songs_nxt = songs_r - 8'd1;
                  state_nxt = (songs_nxt != 8'd0) ? 5'd4 : TAG_IDLE;
                end
              end
            end
            5'd30: begin
              if (clips_r != 16'd0) clips_nxt = clips_r - 16'd1;
              if (clips_nxt != 16'd0) state_nxt = 5'd24;
              else begin
                if (songs_r != 8'd0) songs_nxt = songs_r - 8'd1;
                state_nxt = (songs_nxt != 8'd0) ? 5'd4 : TAG_IDLE;
              end
            end
            default: state_nxt = state_r + 5'd1;
          endcase
        end
      end
    end else if (err_r == ERR_NONE) begin
      err_nxt = ERR_TRAIL; eofs_nxt = ofs_r; state_nxt = TAG_IDLE;
    end

    if (in_item.final_byte && err_nxt == ERR_NONE && state_nxt != TAG_IDLE) begin
      err_nxt  = ERR_TRUNC;
      eofs_nxt = ({7'd0, bif_nxt} <= endo) ? endo - {7'd0, bif_nxt} : 23'd0;
      state_nxt = TAG_IDLE;
    end
    if (endo > cfg.max_file_bytes) begin
      err_nxt = ERR_SIZE; eofs_nxt = 23'd0; state_nxt = TAG_IDLE;
    end
    ofs_nxt = endo;

    res_nxt.field_tag        = tag;
    res_nxt.field_byte_index = idx;
    res_nxt.error_code       = err_nxt;
    res_nxt.error_offset     = eofs_nxt;
    res_nxt.finished         = in_item.final_byte;
    res_nxt.file_ok          = in_item.final_byte && (err_nxt == ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_item.final_byte)) begin
      state_r <= 5'd0; bif_r <= 16'd0; acc_r <= 32'd0;
      songs_r <= 8'd0; scenes_r <= 16'd0; clips_r <= 16'd0;
      ofs_r <= 23'd0; err_r <= ERR_NONE; eofs_r <= 23'd0; pend_r <= ERR_NONE;
    end else if (step) begin
      state_r <= state_nxt; bif_r <= bif_nxt; acc_r <= acc_nxt;
      songs_r <= songs_nxt; scenes_r <= scenes_nxt; clips_r <= clips_nxt;
      ofs_r <= ofs_nxt; err_r <= err_nxt; eofs_r <= eofs_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (in_ready) begin
      ov_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end
endmodule

### rtl/show_container_stream_validator_top.sv
// Show container stream validator.
// An accepted byte passes the queue, then the parse stage, before its result is shown.
// Throughput: one byte per cycle while the output is not stalled, set by the field walk in scv_parse.
// A two-entry queue lets intake run on while the output stalls.
// Reset (rst_n low, synchronous) clears the queue, the parser and the registers to defaults;
// the parser also returns to its reset state after each final byte.
`include "show_container_stream_validator_top_assert.svh"
module show_container_stream_validator_top import scv_pkg::*; #(
  parameter int unsigned ID_LIMIT   = ID_LIMIT_DEF,
  parameter int unsigned NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_field_tag,
  output logic [15:0] out_field_byte_index,
  output logic [3:0]  out_error_code,
  output logic [22:0] out_error_offset,
  output logic        out_finished,
  output logic        out_file_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);
  cfg_t    cfg;
  item_t   q_item, in_item;
  logic    q_valid, q_ready;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{data_byte: in_data_byte, final_byte: in_final_byte};

  scv_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  scv_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_valid), .wr_ready(in_ready),
    .wr_data(in_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
  );

  scv_parse #(.ID_LIMIT(ID_LIMIT), .NAME_LIMIT(NAME_LIMIT)) u_parse (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_valid(q_valid), .in_ready(q_ready),
    .in_item(q_item), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_field_tag        = res.field_tag;
  assign out_field_byte_index = res.field_byte_index;
  assign out_error_code       = res.error_code;
  assign out_error_offset     = res.error_offset;
  assign out_finished         = res.finished;
  assign out_file_ok          = res.file_ok;

  `SCV_ASSERT_IMP(a_ok_fin, clk, rst_n, out_valid && out_file_ok, out_finished && (out_error_code == ERR_NONE), "file_ok without clean finish")
  `SCV_ASSERT_IMP(a_idle_idx, clk, rst_n, out_valid && (out_field_tag == TAG_IDLE), out_field_byte_index == 16'd0, "idle tag with nonzero index")
  `SCV_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res), "result changed under stall")
endmodule
